// ----- rtl/bhtq_pkg.sv -----
// shared types and constants for the binary heap timer queue
package bhtq_pkg;

    localparam int QueueDepthDefault = 32;
    localparam int TimeWidthDefault  = 48;

    localparam int SlotWidth   = 5;
    localparam int HandleWidth = 16;
    localparam int DelayWidth  = 33;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ADD_ACK    = 2'd0,
        KIND_CANCEL_ACK = 2'd1,
        KIND_EXPIRED    = 2'd2,
        KIND_SUMMARY    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOT_USED = 2'd2
    } status_t;

    localparam logic [DelayWidth-1:0] DelayNone = '1;
    localparam logic [DelayWidth-1:0] DelayMax  = {1'b0, {(DelayWidth-1){1'b1}}};

endpackage

// ----- rtl/binary_heap_timer_queue_unit.sv -----
// binary min-heap timer queue: heap entries and per-slot data in synchronous rams with registered reads
// add: claims a free slot and sifts the new entry up the heap; cancel: marks an in-use slot cancelled
// tick: advances time, pops each expired or cancelled top timer (reported if notify is set) with a
//   sift-down after each pop, then sends a summary item; output stalls hold the walk
// one item at a time: s_tready is high only while idle, so the heap walk sets the rate
// synchronous reset empties the heap, frees all slots and zeroes time; ram contents stay
module binary_heap_timer_queue_unit
    import bhtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int TIME_WIDTH  = TimeWidthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    // handle[15:0], timeout[47:16], notify[48], slot[53:49], elapsed[69:54], pad[71:70]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    // slot_out[4:0], handle_out[20:5], status[22:21], next_delay[55:23]
    output logic [55:0] m_tdata,
    output logic        m_tlast
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = AW + 1;
    localparam int HW = TIME_WIDTH + AW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD, ST_UP_RD, ST_UP_CMP, ST_CAN,
        ST_TOP_RD, ST_TOP_SLOT, ST_TOP_CHK, ST_POP_RD, ST_POP_WR,
        ST_DN_RD, ST_DN_RD2, ST_DN_CMP, ST_SUM, ST_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [QUEUE_DEPTH-1:0] in_use_reg;
    logic [53:0] in_reg;
    logic [CW-1:0] k_reg;
    logic [HW-1:0] cur_reg, c1_reg;
    logic [CW-1:0] c1i_reg;
    logic [AW-1:0] slot_reg;
    logic [CW-1:0] nres_reg;
    logic out_valid_reg, out_last_reg, res_last_reg;
    logic [57:0] out_data_reg, res_data_reg;
    state_t ret_reg;

    // heap ram: {deadline, slot}, index k-1
    logic h_we;
    logic [AW-1:0] h_wa, h_ra;
    logic [HW-1:0] h_wd, h_rd;
    bhtq_ram #(.Width(HW), .Depth(QUEUE_DEPTH)) u_heap (
        .aclk, .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd), .rd_addr(h_ra), .rd_data(h_rd)
    );
    // slot ram: {handle, notify, cancelled}
    logic p_we;
    logic [AW-1:0] p_wa, p_ra;
    logic [HandleWidth+1:0] p_wd, p_rd;
    bhtq_ram #(.Width(HandleWidth+2), .Depth(QUEUE_DEPTH)) u_slot (
        .aclk, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd)
    );

    wire [15:0] f_hdl  = in_reg[15:0];
    wire [31:0] f_tmo  = in_reg[47:16];
    wire        f_ntf  = in_reg[48];
    wire [4:0]  f_slot = in_reg[53:49];

    logic [AW-1:0] free_slot;
    logic free_found;
    always_comb begin
        free_slot = '0;
        free_found = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_slot = AW'(i);
                free_found = 1'b1;
            end
        end
    end

    wire [TIME_WIDTH-1:0] h_dl  = h_rd[HW-1:AW];
    wire [AW-1:0]         h_sl  = h_rd[AW-1:0];
    wire [TIME_WIDTH-1:0] cur_dl = cur_reg[HW-1:AW];
    wire [CW:0] k2 = {k_reg, 1'b0};
    logic [TIME_WIDTH:0] dly_w;
    assign dly_w = {1'b0, h_dl} - {1'b0, time_reg};
    wire cancel_ok = ({27'd0, f_slot} < 32'(QUEUE_DEPTH)) && in_use_reg[AW'(f_slot)];

    function automatic logic [57:0] pack(kind_t k, logic [4:0] s, logic [15:0] h,
                                         status_t st, logic [DelayWidth-1:0] d);
        pack = {d, st, h, s, k};
    endfunction

    // ram ports: heap address is the 1-based index minus one; slot ram holds per-slot data
    always_comb begin
        h_we = 1'b0; h_wa = '0; h_wd = cur_reg; h_ra = '0;
        p_we = 1'b0; p_wa = free_slot; p_wd = {f_hdl, f_ntf, 1'b0}; p_ra = slot_reg;
        case (state_reg)
            ST_ADD: begin
                p_we = free_found && (count_reg < CW'(QUEUE_DEPTH));
            end
            ST_UP_RD: h_ra = AW'((k_reg >> 1) - 1'b1);
            ST_CAN: begin
                p_ra = AW'(f_slot);
            end
            ST_TOP_RD: h_ra = '0;
            ST_TOP_SLOT: p_ra = h_sl;
            ST_POP_RD: h_ra = AW'(count_reg - 1'b1);
            ST_DN_RD: h_ra = AW'(k2 - 1'b1);
            ST_DN_RD2: h_ra = AW'(k2);
            ST_SUM: h_ra = '0;
            default: ;
        endcase
        if (state_reg == ST_UP_CMP) begin
            h_we = 1'b1;
            h_wa = AW'(k_reg - 1'b1);
            h_wd = (k_reg > 1 && cur_dl < h_dl) ? h_rd : cur_reg;
        end
        if (state_reg == ST_DN_CMP) begin
            h_we = 1'b1;
            h_wa = AW'(k_reg - 1'b1);
            h_wd = (c1_reg[HW-1:AW] < cur_dl) ? c1_reg : cur_reg;
        end
        if (state_reg == ST_CAN && cancel_ok) begin
            // read-modify-write of the cancelled bit completes in ST_POP_WR
            p_ra = AW'(f_slot);
        end
        if (state_reg == ST_POP_WR && ret_reg == ST_CAN) begin
            p_we = 1'b1; p_wa = slot_reg; p_wd = {p_rd[HandleWidth+1:2], p_rd[1], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            time_reg <= '0;
            in_use_reg <= '0;
            out_valid_reg <= 1'b0;
            nres_reg <= '0;
        end else begin
            if (out_valid_reg && m_tready && state_reg != ST_OUT) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_reg <= s_tdata[53:0];
                        nres_reg <= '0;
                        case (cmd_t'(s_tuser))
                            CMD_ADD:    state_reg <= ST_ADD;
                            CMD_CANCEL: state_reg <= ST_CAN;
                            CMD_TICK: begin
                                time_reg <= time_reg + TIME_WIDTH'(s_tdata[69:54]);
                                state_reg <= ST_TOP_RD;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (!free_found || count_reg >= CW'(QUEUE_DEPTH)) begin
                        res_data_reg <= pack(KIND_ADD_ACK, 5'd0, 16'd0, STAT_FULL, '0);
                        res_last_reg <= 1'b1;
                        state_reg <= ST_OUT;
                        ret_reg <= ST_IDLE;
                    end else begin
                        in_use_reg[free_slot] <= 1'b1;
                        slot_reg <= free_slot;
                        count_reg <= count_reg + 1'b1;
                        k_reg <= count_reg + 1'b1;
                        cur_reg <= {time_reg + TIME_WIDTH'(f_tmo), free_slot};
                        state_reg <= ST_UP_RD;
                    end
                end
                ST_UP_RD: state_reg <= ST_UP_CMP;
                ST_UP_CMP: begin
                    if (k_reg > 1 && cur_dl < h_dl) begin
                        k_reg <= k_reg >> 1;
                        state_reg <= ST_UP_RD;
                    end else begin
                        res_data_reg <= pack(KIND_ADD_ACK, 5'(slot_reg), 16'd0, STAT_OK, '0);
                        res_last_reg <= 1'b1;
                        state_reg <= ST_OUT;
                        ret_reg <= ST_IDLE;
                    end
                end
                ST_CAN: begin
                    res_last_reg <= 1'b1;
                    if (cancel_ok) begin
                        slot_reg <= AW'(f_slot);
                        res_data_reg <= pack(KIND_CANCEL_ACK, 5'd0, 16'd0, STAT_OK, '0);
                        ret_reg <= ST_CAN;
                        state_reg <= ST_POP_WR;
                    end else begin
                        res_data_reg <= pack(KIND_CANCEL_ACK, 5'd0, 16'd0, STAT_NOT_USED, '0);
                        ret_reg <= ST_IDLE;
                        state_reg <= ST_OUT;
                    end
                end
                ST_TOP_RD: begin
                    ret_reg <= ST_TOP_RD;
                    state_reg <= (count_reg == 0) ? ST_SUM : ST_TOP_SLOT;
                end
                ST_TOP_SLOT: begin
                    slot_reg <= h_sl;
                    cur_reg <= h_rd;
                    state_reg <= ST_TOP_CHK;
                end
                ST_TOP_CHK: begin
                    // p_rd holds the top slot's data
                    if (!p_rd[0] && cur_dl > time_reg) begin
                        state_reg <= ST_SUM;
                    end else begin
                        in_use_reg[slot_reg] <= 1'b0;
                        if (!p_rd[0] && p_rd[1] && nres_reg < CW'(QUEUE_DEPTH)) begin
                            res_data_reg <= pack(KIND_EXPIRED, 5'(slot_reg),
                                                 p_rd[HandleWidth+1:2], STAT_OK, '0);
                            res_last_reg <= 1'b0;
                            nres_reg <= nres_reg + 1'b1;
                            ret_reg <= ST_POP_RD;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_POP_RD;
                        end
                    end
                end
                ST_POP_RD: begin
                    count_reg <= count_reg - 1'b1;
                    k_reg <= CW'(1);
                    state_reg <= ST_POP_WR;
                end
                ST_POP_WR: begin
                    if (ret_reg == ST_CAN) begin
                        ret_reg <= ST_IDLE;
                        state_reg <= ST_OUT;
                    end else begin
                        cur_reg <= h_rd;
                        state_reg <= ST_DN_RD;
                    end
                end
                ST_DN_RD: begin
                    if (k2 > {1'b0, count_reg}) begin
                        // no child: place element at k
                        c1_reg <= cur_reg;
                        state_reg <= ST_DN_CMP;
                    end else begin
                        state_reg <= ST_DN_RD2;
                    end
                end
                ST_DN_RD2: begin
                    c1_reg <= h_rd;
                    c1i_reg <= CW'(k2);
                    state_reg <= ST_DN_CMP;
                end
                ST_DN_CMP: begin
                    if (k2 < {1'b0, count_reg} && c1_reg != cur_reg
                        && h_dl < c1_reg[HW-1:AW] && c1i_reg == CW'(k2)) begin
                        // right child smaller: retry compare with it
                        c1_reg <= h_rd;
                        c1i_reg <= CW'(k2 + 1'b1);
                        state_reg <= ST_DN_CMP;
                    end else if (c1_reg != cur_reg && c1_reg[HW-1:AW] < cur_dl) begin
                        k_reg <= c1i_reg;
                        state_reg <= ST_DN_RD;
                    end else begin
                        state_reg <= ST_TOP_RD;
                    end
                end
                ST_SUM: begin
                    if (ret_reg == ST_TOP_RD) begin
                        ret_reg <= ST_SUM;
                    end else begin
                        res_last_reg <= 1'b1;
                        if (count_reg == 0)
                            res_data_reg <= pack(KIND_SUMMARY, 5'd0, 16'd0, STAT_OK, DelayNone);
                        else if (h_dl <= time_reg)
                            res_data_reg <= pack(KIND_SUMMARY, 5'd0, 16'd0, STAT_OK, '0);
                        else if (dly_w > (TIME_WIDTH+1)'(DelayMax))
                            res_data_reg <= pack(KIND_SUMMARY, 5'd0, 16'd0, STAT_OK, DelayMax);
                        else
                            res_data_reg <= pack(KIND_SUMMARY, 5'd0, 16'd0, STAT_OK,
                                                 DelayWidth'(dly_w));
                        ret_reg <= ST_IDLE;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // the item moves to the output register once it is free
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= res_data_reg;
                        out_last_reg <= res_last_reg;
                        state_reg <= ret_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg[1:0];
    assign m_tdata  = out_data_reg[57:2];
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("heap count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != CMD_NONE) |=> !s_tready)
        else $error("accepted while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast)) else $error("result dropped");
`endif
endmodule

// ----- rtl/bhtq_ram.sv -----
// generic single-port-write, single-read synchronous ram
module bhtq_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
